// ===== sv/bfm_pkg.sv =====
`timescale 1ns / 1ps
// Shared constants and types for the box-filter mipmap generator.
// Depends on nothing; every other file of the block imports it.

package bfm_pkg;

  // Default sizing, handed to the top-level parameters.
  localparam int DEF_MAX_WIDTH    = 1024;
  localparam int DEF_MAX_LEVELS   = 8;
  localparam int DEF_MAX_CHANNELS = 2;
  localparam int DEF_SAMPLE_BITS  = 16;

  // Fixed field widths of the configuration registers and result items.
  localparam int CFG_DIM_W = 11;
  localparam int CFG_CH_W  = 2;
  localparam int CFG_LV_W  = 4;
  localparam int LEVEL_W   = 3;
  localparam int BLOCK_W   = 9;

  // Register port sizing.
  localparam int APB_ADDR_W = 4;
  localparam int APB_DATA_W = 32;

  // Number of result groups the output queue holds.
  localparam int GRP_DEPTH = 4;

  // Register indexes (paddr word address).
  localparam logic [1:0] REG_IMAGE_WIDTH   = 2'd0;
  localparam logic [1:0] REG_IMAGE_HEIGHT  = 2'd1;
  localparam logic [1:0] REG_CHANNEL_COUNT = 2'd2;
  localparam logic [1:0] REG_LEVEL_COUNT   = 2'd3;

  // Register reset values.
  localparam logic [CFG_DIM_W-1:0] RST_IMAGE_WIDTH   = 11'd1024;
  localparam logic [CFG_DIM_W-1:0] RST_IMAGE_HEIGHT  = 11'd1024;
  localparam logic [CFG_CH_W-1:0]  RST_CHANNEL_COUNT = 2'd1;
  localparam logic [CFG_LV_W-1:0]  RST_LEVEL_COUNT   = 4'd1;

  // Write control for one level's sum bank.
  typedef struct packed {
    logic valid;  // an item sits in the update stage
    logic en;     // this level is enabled by level_count
  } bfm_wr_ctl_t;

endpackage

// ===== sv/box_filter_mipmap_generator.sv =====
`timescale 1ns / 1ps
// Top level of the box-filter mipmap generator: register port, texel position
// tracking and the update stage. Uses bfm_pkg, bfm_sum_bank, bfm_result_queue.

// The block takes one texel item per clock while in_stall is low. Each
// accepted texel reads the running sum of its block at every enabled level
// in the cycle it is accepted (one sum memory per level) and writes the
// updated sum; with an empty queue, its first result item goes from the
// update stage through the group queue to the output register. Texels that
// complete blocks push one group of averages into a queue of four groups;
// the group is sent one level per cycle while out_stall is low, ascending,
// with last_result marking its final item. in_stall rises while the queue
// holds, or is about to hold, four groups. With results taken every cycle
// this happens only after texels that complete many levels close together,
// and otherwise one texel item is taken every cycle. The sum memories need no
// clearing after reset: every block sum starts fresh at its top-left texel.

module box_filter_mipmap_generator
  import bfm_pkg::*;
#(
  parameter int MAX_WIDTH    = DEF_MAX_WIDTH,
  parameter int MAX_LEVELS   = DEF_MAX_LEVELS,
  parameter int MAX_CHANNELS = DEF_MAX_CHANNELS,
  parameter int SAMPLE_BITS  = DEF_SAMPLE_BITS
) (
  input  logic                          clk,
  input  logic                          rst_n,
  // Register port
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [APB_ADDR_W-1:0]         paddr,
  input  logic [APB_DATA_W-1:0]         pwdata,
  output logic [APB_DATA_W-1:0]         prdata,
  output logic                          pready,
  // Texel input
  input  logic                          in_valid,
  output logic                          in_stall,
  input  logic signed [SAMPLE_BITS-1:0] in_sample_a,
  input  logic signed [SAMPLE_BITS-1:0] in_sample_b,
  input  logic                          in_frame_start,
  // Block average output
  output logic                          out_valid,
  input  logic                          out_stall,
  output logic [LEVEL_W-1:0]            out_level,
  output logic [BLOCK_W-1:0]            out_block_col,
  output logic [BLOCK_W-1:0]            out_block_row,
  output logic signed [SAMPLE_BITS-1:0] out_average_a,
  output logic signed [SAMPLE_BITS-1:0] out_average_b,
  output logic                          out_last_result
);

  localparam int CW   = $clog2(MAX_WIDTH);
  localparam int PW   = $clog2(MAX_WIDTH + 1);
  localparam int EW   = (PW > CFG_DIM_W) ? PW : CFG_DIM_W;
  localparam int NL   = MAX_LEVELS - 1;
  localparam int NCH  = MAX_CHANNELS;
  localparam int CNTW = $clog2(GRP_DEPTH + 1);

  // Configuration registers.
  logic [CFG_DIM_W-1:0] image_width_r;
  logic [CFG_DIM_W-1:0] image_height_r;
  logic [CFG_CH_W-1:0]  channel_count_r;
  logic [CFG_LV_W-1:0]  level_count_r;

  // Position and update stage.
  logic [CW-1:0]              col_r, col_nxt;
  logic [CW-1:0]              row_r, row_nxt;
  logic                       s1_valid_r;
  logic [CW-1:0]              s1_col_r;
  logic [CW-1:0]              s1_row_r;
  logic [NCH*SAMPLE_BITS-1:0] s1_smp_r;

  logic                       cfg_wr;
  logic [EW-1:0]              w_x;
  logic [EW-1:0]              h_x;
  logic [EW-1:0]              w_clamp;
  logic [EW-1:0]              h_clamp;
  logic [PW-1:0]              w_eff;
  logic [PW-1:0]              h_eff;
  logic                       two_ch;
  logic [PW-1:0]              c0, c1, cn;
  logic [PW-1:0]              r0, r1, r2, rn;
  logic [CW-1:0]              cur_col;
  logic [CW-1:0]              cur_row;
  logic                       in_acc;
  logic [NCH*SAMPLE_BITS-1:0] in_smp;
  logic [NL-1:0]              done_w;
  logic [NL-1:0][SAMPLE_BITS-1:0] avg_a_w;
  logic [NL-1:0][SAMPLE_BITS-1:0] avg_b_w;
  logic                       s1_grp;
  logic [CNTW-1:0]            q_count;
  logic [CNTW:0]              q_need;

  // Register writes and reads.
  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      image_width_r   <= RST_IMAGE_WIDTH;
      image_height_r  <= RST_IMAGE_HEIGHT;
      channel_count_r <= RST_CHANNEL_COUNT;
      level_count_r   <= RST_LEVEL_COUNT;
    end else if (cfg_wr) begin
      case (paddr[APB_ADDR_W-1:2])
        REG_IMAGE_WIDTH:   image_width_r   <= pwdata[CFG_DIM_W-1:0];
        REG_IMAGE_HEIGHT:  image_height_r  <= pwdata[CFG_DIM_W-1:0];
        REG_CHANNEL_COUNT: channel_count_r <= pwdata[CFG_CH_W-1:0];
        REG_LEVEL_COUNT:   level_count_r   <= pwdata[CFG_LV_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (paddr[APB_ADDR_W-1:2])
      REG_IMAGE_WIDTH:   prdata = APB_DATA_W'(image_width_r);
      REG_IMAGE_HEIGHT:  prdata = APB_DATA_W'(image_height_r);
      REG_CHANNEL_COUNT: prdata = APB_DATA_W'(channel_count_r);
      REG_LEVEL_COUNT:   prdata = APB_DATA_W'(level_count_r);
      default:           prdata = '0;
    endcase
  end

  // Effective image size and channel mode, clamped to the supported range.
  assign w_x     = EW'(image_width_r);
  assign h_x     = EW'(image_height_r);
  assign w_clamp = (w_x == '0) ? EW'(1) : ((w_x > EW'(MAX_WIDTH)) ? EW'(MAX_WIDTH) : w_x);
  assign h_clamp = (h_x == '0) ? EW'(1) : ((h_x > EW'(MAX_WIDTH)) ? EW'(MAX_WIDTH) : h_x);
  assign w_eff   = w_clamp[PW-1:0];
  assign h_eff   = h_clamp[PW-1:0];
  assign two_ch  = (MAX_CHANNELS > 1) && (channel_count_r >= CFG_CH_W'(2));

  // Position of the texel on the input, with frame start and wrap handling.
  always_comb begin
    c0 = in_frame_start ? '0 : PW'(col_r);
    r0 = in_frame_start ? '0 : PW'(row_r);
    if (c0 >= w_eff) begin
      c1 = '0;
      r1 = r0 + PW'(1);
    end else begin
      c1 = c0;
      r1 = r0;
    end
    r2      = (r1 >= h_eff) ? '0 : r1;
    cur_col = c1[CW-1:0];
    cur_row = r2[CW-1:0];
    cn      = c1 + PW'(1);
    rn      = r2 + PW'(1);
    if (cn >= w_eff) begin
      col_nxt = '0;
      row_nxt = (rn >= h_eff) ? '0 : rn[CW-1:0];
    end else begin
      col_nxt = cn[CW-1:0];
      row_nxt = cur_row;
    end
  end

  // Accept unless the result queue might run out of group slots.
  assign s1_grp   = |done_w;
  assign q_need   = {1'b0, q_count} + (CNTW + 1)'(s1_grp);
  assign in_stall = q_need >= (CNTW + 1)'(GRP_DEPTH);
  assign in_acc   = in_valid && !in_stall;

  if (NCH > 1) begin : g_smp2
    assign in_smp = {in_sample_b, in_sample_a};
  end else begin : g_smp1
    assign in_smp = in_sample_a;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      col_r      <= '0;
      row_r      <= '0;
      s1_valid_r <= 1'b0;
    end else begin
      s1_valid_r <= in_acc;
      if (in_acc) begin
        col_r <= col_nxt;
        row_r <= row_nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      s1_col_r <= cur_col;
      s1_row_r <= cur_row;
      s1_smp_r <= in_smp;
    end
  end

  // One sum bank per reduced level that has at least one block column.
  for (genvar g = 0; g < NL; g++) begin : g_level
    if ((MAX_WIDTH >> (g + 1)) >= 1) begin : g_bank
      bfm_wr_ctl_t                wr_ctl;
      logic [NCH*SAMPLE_BITS-1:0] bank_avg;

      assign wr_ctl.valid = s1_valid_r;
      assign wr_ctl.en    = level_count_r > CFG_LV_W'(g + 1);

      bfm_sum_bank #(
        .LEVEL       (g + 1),
        .MAX_WIDTH   (MAX_WIDTH),
        .NCH         (NCH),
        .SAMPLE_BITS (SAMPLE_BITS)
      ) u_bank (
        .clk    (clk),
        .rst_n  (rst_n),
        .rd_en  (in_acc),
        .rd_col (cur_col),
        .wr_ctl (wr_ctl),
        .wr_col (s1_col_r),
        .wr_row (s1_row_r),
        .wr_smp (s1_smp_r),
        .done   (done_w[g]),
        .avg    (bank_avg)
      );

      assign avg_a_w[g] = bank_avg[SAMPLE_BITS-1:0];
      if (NCH > 1) begin : g_b
        assign avg_b_w[g] = bank_avg[2*SAMPLE_BITS-1:SAMPLE_BITS];
      end else begin : g_nob
        assign avg_b_w[g] = '0;
      end
    end else begin : g_none
      assign done_w[g]  = 1'b0;
      assign avg_a_w[g] = '0;
      assign avg_b_w[g] = '0;
    end
  end

  // Result groups and the output item register.
  bfm_result_queue #(
    .NL          (NL),
    .CW          (CW),
    .SAMPLE_BITS (SAMPLE_BITS),
    .DEPTH       (GRP_DEPTH)
  ) u_queue (
    .clk             (clk),
    .rst_n           (rst_n),
    .push            (s1_grp),
    .push_mask       (done_w),
    .push_col        (s1_col_r),
    .push_row        (s1_row_r),
    .push_avg_a      (avg_a_w),
    .push_avg_b      (avg_b_w),
    .two_ch          (two_ch),
    .count           (q_count),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .out_level       (out_level),
    .out_block_col   (out_block_col),
    .out_block_row   (out_block_row),
    .out_average_a   (out_average_a),
    .out_average_b   (out_average_b),
    .out_last_result (out_last_result)
  );

endmodule

// ===== sv/bfm_sum_bank.sv =====
`timescale 1ns / 1ps
// Running block sums of one mip level: a synchronous memory with one entry
// per block column, read-modify-write with forwarding. Uses bfm_pkg.

module bfm_sum_bank
  import bfm_pkg::*;
#(
  parameter int LEVEL       = 1,
  parameter int MAX_WIDTH   = DEF_MAX_WIDTH,
  parameter int NCH         = DEF_MAX_CHANNELS,
  parameter int SAMPLE_BITS = DEF_SAMPLE_BITS
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          rd_en,
  input  logic [$clog2(MAX_WIDTH)-1:0]  rd_col,
  input  bfm_wr_ctl_t                   wr_ctl,
  input  logic [$clog2(MAX_WIDTH)-1:0]  wr_col,
  input  logic [$clog2(MAX_WIDTH)-1:0]  wr_row,
  input  logic [NCH*SAMPLE_BITS-1:0]    wr_smp,
  output logic                          done,
  output logic [NCH*SAMPLE_BITS-1:0]    avg
);

  localparam int CW    = $clog2(MAX_WIDTH);
  localparam int DEPTH = MAX_WIDTH >> LEVEL;
  localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int SW    = SAMPLE_BITS + 2 * LEVEL;
  localparam int DW    = NCH * SW;
  localparam logic [CW-1:0] MASK = CW'((1 << LEVEL) - 1);

  logic [DW-1:0] mem [DEPTH];
  logic [DW-1:0] rd_data_r;
  logic          fwd_valid_r;
  logic [AW-1:0] fwd_addr_r;
  logic [DW-1:0] fwd_data_r;

  logic [CW-1:0] rd_shift;
  logic [AW-1:0] rd_addr;
  logic [CW-1:0] wr_shift;
  logic [AW-1:0] wr_addr;
  logic          wr_in_range;
  logic          blk_first;
  logic          blk_last;
  logic          we;
  logic [DW-1:0] old_word;
  logic [DW-1:0] new_word;

  // Address of the block column for the item being read and being updated.
  assign rd_shift    = rd_col >> LEVEL;
  assign rd_addr     = rd_shift[AW-1:0];
  assign wr_shift    = wr_col >> LEVEL;
  assign wr_addr     = wr_shift[AW-1:0];
  assign wr_in_range = wr_shift < CW'(DEPTH);

  // Top-left texel starts a block sum, bottom-right texel completes it.
  assign blk_first = ((wr_col & MASK) == '0) && ((wr_row & MASK) == '0);
  assign blk_last  = ((wr_col & MASK) == MASK) && ((wr_row & MASK) == MASK);
  assign we        = wr_ctl.valid && wr_ctl.en && wr_in_range;
  assign done      = we && blk_last;

  // The previous item's write lands on the same edge as this item's read.
  assign old_word = (fwd_valid_r && (fwd_addr_r == wr_addr)) ? fwd_data_r : rd_data_r;

  // Per-channel accumulate; the average is the sum shifted right by 2L.
  for (genvar c = 0; c < NCH; c++) begin : g_lane
    logic [SW-1:0] smp_ext;
    assign smp_ext = {{(2 * LEVEL){wr_smp[c*SAMPLE_BITS + SAMPLE_BITS - 1]}},
                      wr_smp[c*SAMPLE_BITS +: SAMPLE_BITS]};
    assign new_word[c*SW +: SW] = blk_first ? smp_ext : (old_word[c*SW +: SW] + smp_ext);
    assign avg[c*SAMPLE_BITS +: SAMPLE_BITS] = new_word[c*SW + 2*LEVEL +: SAMPLE_BITS];
  end

  // Sum memory: one read and one write port, registered read data.
  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data_r <= mem[rd_addr];
    end
    if (we) begin
      mem[wr_addr] <= new_word;
    end
  end

  // Most recent write, kept for forwarding.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fwd_valid_r <= 1'b0;
    end else if (we) begin
      fwd_valid_r <= 1'b1;
    end
    if (we) begin
      fwd_addr_r <= wr_addr;
      fwd_data_r <= new_word;
    end
  end

endmodule

// ===== sv/bfm_result_queue.sv =====
`timescale 1ns / 1ps
// Queue of result groups, one group per texel that completes blocks, and
// the serializer that sends the group's levels out one item at a time. Uses bfm_pkg.

module bfm_result_queue
  import bfm_pkg::*;
#(
  parameter int NL          = DEF_MAX_LEVELS - 1,
  parameter int CW          = $clog2(DEF_MAX_WIDTH),
  parameter int SAMPLE_BITS = DEF_SAMPLE_BITS,
  parameter int DEPTH       = GRP_DEPTH
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              push,
  input  logic [NL-1:0]                     push_mask,
  input  logic [CW-1:0]                     push_col,
  input  logic [CW-1:0]                     push_row,
  input  logic [NL-1:0][SAMPLE_BITS-1:0]    push_avg_a,
  input  logic [NL-1:0][SAMPLE_BITS-1:0]    push_avg_b,
  input  logic                              two_ch,
  output logic [$clog2(DEPTH+1)-1:0]        count,
  output logic                              out_valid,
  input  logic                              out_stall,
  output logic [LEVEL_W-1:0]                out_level,
  output logic [BLOCK_W-1:0]                out_block_col,
  output logic [BLOCK_W-1:0]                out_block_row,
  output logic signed [SAMPLE_BITS-1:0]     out_average_a,
  output logic signed [SAMPLE_BITS-1:0]     out_average_b,
  output logic                              out_last_result
);

  localparam int PTRW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNTW = $clog2(DEPTH + 1);
  localparam int SELW = (NL > 1) ? $clog2(NL) : 1;
  localparam int LNW  = $clog2(NL + 1);
  localparam int LXW  = (LNW > LEVEL_W) ? LNW : LEVEL_W;
  localparam int XW   = (CW > BLOCK_W) ? CW : BLOCK_W;

  // Group storage.
  logic [NL-1:0]                  ent_mask [DEPTH];
  logic [CW-1:0]                  ent_col  [DEPTH];
  logic [CW-1:0]                  ent_row  [DEPTH];
  logic [NL-1:0][SAMPLE_BITS-1:0] ent_a    [DEPTH];
  logic [NL-1:0][SAMPLE_BITS-1:0] ent_b    [DEPTH];

  logic [PTRW-1:0] wptr_r, wptr_nxt;
  logic [PTRW-1:0] rptr_r, rptr_nxt;
  logic [CNTW-1:0] count_r, count_nxt;
  logic [NL-1:0]   served_r, served_nxt;
  logic            out_valid_r;

  logic [LEVEL_W-1:0]     out_level_r;
  logic [BLOCK_W-1:0]     out_block_col_r;
  logic [BLOCK_W-1:0]     out_block_row_r;
  logic [SAMPLE_BITS-1:0] out_average_a_r;
  logic [SAMPLE_BITS-1:0] out_average_b_r;
  logic                   out_last_result_r;

  logic [NL-1:0]   head_mask;
  logic [NL-1:0]   rem;
  logic [NL-1:0]   sel_oh;
  logic [SELW-1:0] sel;
  logic            grp_last;
  logic            can_load;
  logic            emit;
  logic            pop;
  logic [LXW-1:0]  lvl_x;
  logic [XW-1:0]   col_x;
  logic [XW-1:0]   row_x;

  // Lowest level of the head group not yet sent.
  assign head_mask = ent_mask[rptr_r];
  assign rem       = head_mask & ~served_r;
  assign sel_oh    = rem & (~rem + NL'(1));
  assign grp_last  = (rem & ~sel_oh) == '0;

  always_comb begin
    sel = '0;
    for (int i = NL - 1; i >= 0; i--) begin
      if (rem[i]) begin
        sel = SELW'(i);
      end
    end
  end

  assign lvl_x = LXW'(sel) + LXW'(1);
  assign col_x = XW'(ent_col[rptr_r]) >> lvl_x;
  assign row_x = XW'(ent_row[rptr_r]) >> lvl_x;

  // Output register takes a new item when empty or being taken.
  assign can_load = !out_valid_r || !out_stall;
  assign emit     = (count_r != '0) && can_load;
  assign pop      = emit && grp_last;

  // Pointer, count and progress through the head group.
  always_comb begin
    wptr_nxt   = wptr_r;
    rptr_nxt   = rptr_r;
    served_nxt = served_r;
    count_nxt  = count_r;
    if (push) begin
      wptr_nxt = (wptr_r == PTRW'(DEPTH - 1)) ? '0 : wptr_r + PTRW'(1);
    end
    if (emit) begin
      if (grp_last) begin
        served_nxt = '0;
        rptr_nxt   = (rptr_r == PTRW'(DEPTH - 1)) ? '0 : rptr_r + PTRW'(1);
      end else begin
        served_nxt = served_r | sel_oh;
      end
    end
    if (push && !pop) begin
      count_nxt = count_r + CNTW'(1);
    end else if (!push && pop) begin
      count_nxt = count_r - CNTW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wptr_r      <= '0;
      rptr_r      <= '0;
      count_r     <= '0;
      served_r    <= '0;
      out_valid_r <= 1'b0;
    end else begin
      wptr_r   <= wptr_nxt;
      rptr_r   <= rptr_nxt;
      count_r  <= count_nxt;
      served_r <= served_nxt;
      if (can_load) begin
        out_valid_r <= emit;
      end
    end
  end

  // Group write on push.
  always_ff @(posedge clk) begin
    if (push) begin
      ent_mask[wptr_r] <= push_mask;
      ent_col[wptr_r]  <= push_col;
      ent_row[wptr_r]  <= push_row;
      ent_a[wptr_r]    <= push_avg_a;
      ent_b[wptr_r]    <= push_avg_b;
    end
  end

  // Result item payload.
  always_ff @(posedge clk) begin
    if (emit) begin
      out_level_r       <= lvl_x[LEVEL_W-1:0];
      out_block_col_r   <= col_x[BLOCK_W-1:0];
      out_block_row_r   <= row_x[BLOCK_W-1:0];
      out_average_a_r   <= ent_a[rptr_r][sel];
      out_average_b_r   <= two_ch ? ent_b[rptr_r][sel] : '0;
      out_last_result_r <= grp_last;
    end
  end

  assign count           = count_r;
  assign out_valid       = out_valid_r;
  assign out_level       = out_level_r;
  assign out_block_col   = out_block_col_r;
  assign out_block_row   = out_block_row_r;
  assign out_average_a   = out_average_a_r;
  assign out_average_b   = out_average_b_r;
  assign out_last_result = out_last_result_r;

  // The input credit check must keep a free group slot for every push.
  a_push_room: assert property (@(posedge clk) disable iff (!rst_n)
    push |-> (count_r < CNTW'(DEPTH)))
    else $error("group pushed into a full queue");

  // A stored group always has a level left to send.
  a_head_pending: assert property (@(posedge clk) disable iff (!rst_n)
    (count_r != '0) |-> (rem != '0))
    else $error("head group has no pending level");

  // Progress marks are cleared whenever the queue runs empty.
  a_served_clear: assert property (@(posedge clk) disable iff (!rst_n)
    (count_r == '0) |-> (served_r == '0))
    else $error("served levels left over in an empty queue");

endmodule

// ===== test/tb_box_filter_mipmap_generator.sv =====
`timescale 1ns / 1ps
// Self-checking testbench for box_filter_mipmap_generator: a scoreboard class
// predicts every block average and checks the output items. Uses bfm_pkg.

import bfm_pkg::*;

// One block average as it leaves the block.
typedef struct {
  logic [LEVEL_W-1:0]                level;
  logic [BLOCK_W-1:0]                block_col;
  logic [BLOCK_W-1:0]                block_row;
  logic signed [DEF_SAMPLE_BITS-1:0] average_a;
  logic signed [DEF_SAMPLE_BITS-1:0] average_b;
  logic                              last_result;
} block_avg_t;

typedef enum int {IDLE_NONE, IDLE_SENDER, IDLE_RECEIVER, IDLE_BOTH} idle_mode_t;

// Scoreboard: keeps its own copy of the registers, the texel position and the
// running block sums, and holds the block averages still to come.
class mip_average_board;
  localparam int unsigned MAX_W = DEF_MAX_WIDTH;

  logic [CFG_DIM_W-1:0] width_reg;
  logic [CFG_DIM_W-1:0] height_reg;
  logic [CFG_CH_W-1:0]  chan_reg;
  logic [CFG_LV_W-1:0]  levels_reg;
  int unsigned          col_pos;
  int unsigned          row_pos;
  longint               sum_a[MAX_W];
  longint               sum_b[MAX_W];
  block_avg_t           expected_averages[$];
  int                   fail_count;

  function new();
    width_reg  = RST_IMAGE_WIDTH;
    height_reg = RST_IMAGE_HEIGHT;
    chan_reg   = RST_CHANNEL_COUNT;
    levels_reg = RST_LEVEL_COUNT;
    col_pos    = 0;
    row_pos    = 0;
    fail_count = 0;
  endfunction

  function void write_reg(logic [1:0] idx, logic [APB_DATA_W-1:0] value);
    case (idx)
      REG_IMAGE_WIDTH:   width_reg  = value[CFG_DIM_W-1:0];
      REG_IMAGE_HEIGHT:  height_reg = value[CFG_DIM_W-1:0];
      REG_CHANNEL_COUNT: chan_reg   = value[CFG_CH_W-1:0];
      REG_LEVEL_COUNT:   levels_reg = value[CFG_LV_W-1:0];
      default: ;
    endcase
  endfunction

  function int unsigned clamp(int unsigned v, int unsigned lo, int unsigned hi);
    if (v < lo) return lo;
    if (v > hi) return hi;
    return v;
  endfunction

  // Accepted texel: advance the position, update the sums of every enabled
  // level and queue the averages of the blocks this texel completes.
  function void note_texel(logic signed [DEF_SAMPLE_BITS-1:0] a,
                           logic signed [DEF_SAMPLE_BITS-1:0] b, logic fs);
    int unsigned w, h, ch, lv, col, row, base, span, msk, bc, idx;
    bit          held;
    block_avg_t  avg, held_avg;
    w    = clamp(width_reg, 1, MAX_W);
    h    = clamp(height_reg, 1, MAX_W);
    ch   = clamp(chan_reg, 1, DEF_MAX_CHANNELS);
    lv   = clamp(levels_reg, 1, DEF_MAX_LEVELS);
    held = 1'b0;
    base = 0;

    // A frame start forces the origin; a stale position wraps.
    if (fs) begin
      col_pos = 0;
      row_pos = 0;
    end
    if (col_pos >= w) begin
      col_pos = 0;
      row_pos++;
    end
    if (row_pos >= h) row_pos = 0;
    col = col_pos;
    row = row_pos;

    for (int lvl = 1; lvl < lv; lvl++) begin
      span = MAX_W >> lvl;
      msk  = (1 << lvl) - 1;
      bc   = col >> lvl;
      idx  = base + bc;
      base += span;
      if (bc < span && idx < MAX_W) begin
        // The top-left texel of a block starts its sum afresh.
        if ((col & msk) == 0 && (row & msk) == 0) begin
          sum_a[idx] = a;
          sum_b[idx] = b;
        end else begin
          sum_a[idx] += a;
          sum_b[idx] += b;
        end
        // The bottom-right texel completes the block.
        if ((col & msk) == msk && (row & msk) == msk) begin
          avg.level       = LEVEL_W'(lvl);
          avg.block_col   = BLOCK_W'(bc);
          avg.block_row   = BLOCK_W'(row >> lvl);
          avg.average_a   = DEF_SAMPLE_BITS'(sum_a[idx] >>> (2 * lvl));
          avg.average_b   = (ch == 2) ? DEF_SAMPLE_BITS'(sum_b[idx] >>> (2 * lvl)) : '0;
          avg.last_result = 1'b0;
          if (held) expected_averages = {expected_averages, held_avg};
          held_avg = avg;
          held     = 1'b1;
        end
      end
    end
    if (held) begin
      held_avg.last_result = 1'b1;
      expected_averages = {expected_averages, held_avg};
    end

    col_pos = col + 1;
    row_pos = row;
    if (col_pos >= w) begin
      col_pos = 0;
      row_pos = row + 1;
      if (row_pos >= h) row_pos = 0;
    end
  endfunction

  function void match_field(string name, longint want, longint got);
    if (want != got) begin
      $error("%s: expected %0d, got %0d", name, want, got);
      fail_count++;
    end
  endfunction

  // Output item: compare with the oldest expected average.
  function void check_average(block_avg_t got);
    block_avg_t want;
    if (expected_averages.size() == 0) begin
      $error("block average with none expected: level %0d col %0d row %0d",
             got.level, got.block_col, got.block_row);
      fail_count++;
      return;
    end
    want = expected_averages.pop_front();
    match_field("level", want.level, got.level);
    match_field("block_col", want.block_col, got.block_col);
    match_field("block_row", want.block_row, got.block_row);
    match_field("average_a", want.average_a, got.average_a);
    match_field("average_b", want.average_b, got.average_b);
    match_field("last_result", want.last_result, got.last_result);
  endfunction

  function int pending();
    return expected_averages.size();
  endfunction
endclass

module tb_box_filter_mipmap_generator;

  localparam int QUIET_CYCLES = 16;
  localparam int RANDOM_ITEMS = 160;
  localparam int DEEP_SIDE    = 16;
  localparam int WIDE_ITEMS   = 40;

  logic                              clk            = 1'b0;
  logic                              rst_n          = 1'b0;
  logic                              psel           = 1'b0;
  logic                              penable        = 1'b0;
  logic                              pwrite         = 1'b0;
  logic [APB_ADDR_W-1:0]             paddr          = '0;
  logic [APB_DATA_W-1:0]             pwdata         = '0;
  logic [APB_DATA_W-1:0]             prdata;
  logic                              pready;
  logic                              in_valid       = 1'b0;
  logic                              in_stall;
  logic signed [DEF_SAMPLE_BITS-1:0] in_sample_a    = '0;
  logic signed [DEF_SAMPLE_BITS-1:0] in_sample_b    = '0;
  logic                              in_frame_start = 1'b0;
  logic                              out_valid;
  logic                              out_stall      = 1'b0;
  logic [LEVEL_W-1:0]                out_level;
  logic [BLOCK_W-1:0]                out_block_col;
  logic [BLOCK_W-1:0]                out_block_row;
  logic signed [DEF_SAMPLE_BITS-1:0] out_average_a;
  logic signed [DEF_SAMPLE_BITS-1:0] out_average_b;
  logic                              out_last_result;

  int               send_gap_pct   = 0;
  int               recv_stall_pct = 0;
  block_avg_t       seen_avg;
  mip_average_board sb = new();

  box_filter_mipmap_generator u_top (
    .clk             (clk),
    .rst_n           (rst_n),
    .psel            (psel),
    .penable         (penable),
    .pwrite          (pwrite),
    .paddr           (paddr),
    .pwdata          (pwdata),
    .prdata          (prdata),
    .pready          (pready),
    .in_valid        (in_valid),
    .in_stall        (in_stall),
    .in_sample_a     (in_sample_a),
    .in_sample_b     (in_sample_b),
    .in_frame_start  (in_frame_start),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .out_level       (out_level),
    .out_block_col   (out_block_col),
    .out_block_row   (out_block_row),
    .out_average_a   (out_average_a),
    .out_average_b   (out_average_b),
    .out_last_result (out_last_result)
  );

  // 50 MHz clock.
  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  // Output side: check each accepted item, then pick the next stall.
  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) begin
      seen_avg.level       = out_level;
      seen_avg.block_col   = out_block_col;
      seen_avg.block_row   = out_block_row;
      seen_avg.average_a   = out_average_a;
      seen_avg.average_b   = out_average_b;
      seen_avg.last_result = out_last_result;
      sb.check_average(seen_avg);
    end
    out_stall <= ($urandom_range(0, 99) < recv_stall_pct);
  end

  // Hard stop in case the block hangs.
  initial begin
    #10_000_000;
    $display("box_filter_mipmap_generator: mismatch");
    $finish;
  end

  task automatic set_idle(input idle_mode_t mode);
    case (mode)
      IDLE_NONE: begin
        send_gap_pct   = 0;
        recv_stall_pct = 0;
      end
      IDLE_SENDER: begin
        send_gap_pct   = 68;
        recv_stall_pct = 0;
      end
      IDLE_RECEIVER: begin
        send_gap_pct   = 0;
        recv_stall_pct = 68;
      end
      default: begin
        send_gap_pct   = 10;
        recv_stall_pct = 10;
      end
    endcase
  endtask

  // Offer one texel item, with random gaps ahead of it, until it is taken.
  task automatic send_texel(input logic signed [DEF_SAMPLE_BITS-1:0] a,
                            input logic signed [DEF_SAMPLE_BITS-1:0] b,
                            input logic fs);
    while ($urandom_range(0, 99) < send_gap_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid       <= 1'b1;
    in_sample_a    <= a;
    in_sample_b    <= b;
    in_frame_start <= fs;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    sb.note_texel(a, b, fs);
  endtask

  // Stop the input and wait until every expected average has come out and
  // the pipeline has had time to finish texels that make no result.
  task automatic wait_block_quiet();
    in_valid <= 1'b0;
    @(posedge clk);
    while (sb.pending() != 0) @(posedge clk);
    repeat (QUIET_CYCLES) @(posedge clk);
  endtask

  // Register write: setup cycle, then access cycle until pready.
  task automatic cfg_write(input logic [1:0] idx, input logic [APB_DATA_W-1:0] value);
    @(posedge clk);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= value;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    sb.write_reg(idx, value);
  endtask

  task automatic apply_setting(input int w, input int h, input int ch, input int lv);
    wait_block_quiet();
    cfg_write(REG_IMAGE_WIDTH, w);
    cfg_write(REG_IMAGE_HEIGHT, h);
    cfg_write(REG_CHANNEL_COUNT, ch);
    cfg_write(REG_LEVEL_COUNT, lv);
  endtask

  function automatic logic signed [DEF_SAMPLE_BITS-1:0] rand_sample();
    case ($urandom_range(0, 9))
      0: return 16'sh8000;
      1: return 16'sh7fff;
      2: return '0;
      3: return -16'sd1;
      default: return DEF_SAMPLE_BITS'($urandom);
    endcase
  endfunction

  // Image sizes: mostly small, now and then zero, one or above the maximum.
  function automatic int pick_dim();
    case ($urandom_range(0, 9))
      0: return 0;
      1: return 1;
      2: return $urandom_range(1025, 2047);
      default: return $urandom_range(2, 16);
    endcase
  endfunction

  function automatic int pick_levels();
    case ($urandom_range(0, 3))
      0: return $urandom_range(0, 15);
      default: return $urandom_range(2, 4);
    endcase
  endfunction

  initial begin
    int random_sent;
    int phase;
    int count;

    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    set_idle(IDLE_NONE);

    // Reset settings: one level only, so nothing comes out.
    send_texel(16'sh7fff, 16'sh8000, 1'b0);
    send_texel(16'sh8000, 16'sh7fff, 1'b1);

    // Smallest block: full-scale samples, then a floor case on a negative sum,
    // the second frame entered by natural wrap.
    apply_setting(2, 2, 2, 2);
    for (int i = 0; i < 4; i++) send_texel(16'sh8000, 16'sh7fff, i == 0);
    send_texel(-16'sd1, 16'sd3, 1'b0);
    for (int i = 0; i < 3; i++) send_texel('0, '0, 1'b0);

    // Width shrinks mid-row, so the position wraps to the next row.
    apply_setting(4, 4, 2, 3);
    for (int i = 0; i < 6; i++) send_texel(rand_sample(), rand_sample(), i == 0);
    wait_block_quiet();
    cfg_write(REG_IMAGE_WIDTH, 2);
    for (int i = 0; i < 2; i++) send_texel(rand_sample(), rand_sample(), 1'b0);

    // Height shrinks below the current row, so the position wraps to row 0.
    wait_block_quiet();
    cfg_write(REG_IMAGE_HEIGHT, 3);
    for (int i = 0; i < 4; i++) send_texel(rand_sample(), rand_sample(), 1'b0);

    // Several levels on full-scale samples: large sums and groups of up to four results.
    apply_setting(DEEP_SIDE, DEEP_SIDE, 2, 8);
    for (int i = 0; i < DEEP_SIDE * DEEP_SIDE; i++) begin
      send_texel(16'sh8000, 16'sh7fff, i == 0);
    end

    // Oversized width and level count, one channel: the first row completes no block.
    set_idle(IDLE_BOTH);
    apply_setting(2047, 2, 1, 15);
    for (int i = 0; i < WIDE_ITEMS; i++) send_texel(rand_sample(), rand_sample(), i == 0);

    // Random settings, each followed by a frame with the odd stray frame start.
    random_sent = 0;
    phase       = 0;
    while (random_sent < RANDOM_ITEMS) begin
      set_idle(idle_mode_t'(phase % 4));
      apply_setting(pick_dim(), pick_dim(), $urandom_range(0, 3), pick_levels());
      count = $urandom_range(20, 40);
      for (int i = 0; i < count; i++) begin
        send_texel(rand_sample(), rand_sample(), (i == 0) || ($urandom_range(0, 99) < 3));
      end
      random_sent += count;
      phase++;
    end

    wait_block_quiet();
    repeat (QUIET_CYCLES) @(posedge clk);
    if (sb.fail_count == 0 && sb.pending() == 0) begin
      $display("box_filter_mipmap_generator: match");
    end else begin
      $display("box_filter_mipmap_generator: mismatch");
    end
    $finish;
  end

endmodule

// ===== box_filter_mipmap_generator.f =====
sv/bfm_pkg.sv
sv/bfm_sum_bank.sv
sv/bfm_result_queue.sv
sv/box_filter_mipmap_generator.sv
test/tb_box_filter_mipmap_generator.sv
